// File: sv/pelt_pkg.sv
// Shared types, constants and codes of the pending event log table.
// No dependencies; used by pelt_cell and pending_event_log_table_core.
`default_nettype none

package pelt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_BODY    = 32;
    localparam int CW          = $clog2(TABLE_DEPTH + 1);
    localparam int CAP_W       = 7;
    localparam int SLOT_W      = 6;
    localparam int PEND_W      = 7;
    localparam logic [7:0] TRIES_MAX = 8'd255;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_SYNC   = 2'd1;
    localparam logic [1:0] CMD_TRY    = 2'd2;
    localparam logic [1:0] CMD_OLDEST = 2'd3;

    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_LENGTH  = 2'd1;
    localparam logic [1:0] RES_NO_ID   = 2'd2;
    localparam logic [1:0] RES_NONE    = 2'd3;

    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_BOOT     = 2'd1;
    localparam logic [1:0] REG_TEST     = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [3:0]  kind;
        logic [7:0]  node;
        logic [7:0]  length;
        logic [31:0] boot;
        logic [31:0] stamp;
        logic        synced;
        logic [7:0]  tries;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DROP,
        ST_INSERT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: sv/pending_event_log_table_core.sv
// Pending event log table: row of entry cells plus the command sequencer.
// Depends on pelt_pkg and pelt_cell.
`default_nettype none

// A command is taken when start is high and busy low; its single result shows
// for one cycle with done high, in the cycle in which busy falls, and cannot be
// held off. With n entries stored, an append that fits goes straight to insertion
// and a rejected append straight to the result; an append that compacts first walks
// all n entries (and then drops the oldest if still full), and mark, count attempt
// and oldest pending walk all n entries (none when the table is empty). The cell row
// rotates one entry past the head per cycle during a walk.
module pending_event_log_table_core
    import pelt_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  cmd,
    input  wire  [3:0]  event_kind,
    input  wire  [7:0]  source_node,
    input  wire  [7:0]  body_length,
    input  wire  [31:0] stamp_ms,
    input  wire  [31:0] target_id,
    input  wire         allow_test,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    output logic        done,
    output logic [1:0]  outcome,
    output logic [31:0] record_id,
    output logic [3:0]  record_kind,
    output logic [7:0]  record_node,
    output logic [7:0]  record_length,
    output logic [31:0] record_boot,
    output logic [31:0] record_stamp,
    output logic [7:0]  record_tries,
    output logic [5:0]  slot_number,
    output logic [6:0]  pending_total,
    output logic [31:0] dropped_total
);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] synced_reg, synced_next;
    logic [31:0] next_id_reg, next_id_next;
    logic [31:0] drop_reg, drop_next;
    logic [CAP_W-1:0] cap_reg;
    logic [31:0] boot_reg;
    logic [3:0] test_reg;
    logic compact_reg, compact_next;
    logic [CW-1:0] iter_reg, iter_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic found_reg, found_next;
    logic [1:0] res_reg, res_next;
    entry_t hit_reg, hit_next;
    logic [CW-1:0] hit_slot_reg, hit_slot_next;
    logic done_reg, done_next;

    // command beat, payload only
    logic [1:0] cmd_reg;
    logic [3:0] kind_reg;
    logic [7:0] node_reg;
    logic [7:0] len_reg;
    logic [31:0] stamp_reg;
    logic [31:0] target_reg;
    logic allow_reg;

    logic [1:0] out_res_reg;
    entry_t out_rec_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [PEND_W-1:0] out_pend_reg;
    logic [31:0] out_drop_reg;

    entry_t cell_q [TABLE_DEPTH];
    cell_ctrl_t cell_ctrl [TABLE_DEPTH];
    entry_t bus;
    entry_t head;
    entry_t new_entry;
    logic step, keep, insert;
    logic [CW-1:0] eff_cap;
    logic accept;
    logic match;

    assign accept = start && (state_reg == ST_IDLE);
    assign head = cell_q[0];

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (int'(cap_reg) > TABLE_DEPTH)
        begin
            eff_cap = CW'(TABLE_DEPTH);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    always_comb
    begin
        new_entry.id     = next_id_reg;
        new_entry.kind   = kind_reg;
        new_entry.node   = node_reg;
        new_entry.length = len_reg;
        new_entry.boot   = boot_reg;
        new_entry.stamp  = stamp_reg;
        new_entry.synced = 1'b0;
        new_entry.tries  = '0;
    end

    // cell row
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_row
        entry_t right_q;
        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign right_q = cell_q[g];
        end
        else
        begin : g_mid
            assign right_q = cell_q[g + 1];
        end

        assign cell_ctrl[g].shift = step && (CW'(g + 1) < count_reg);
        assign cell_ctrl[g].load  = (step && keep && (CW'(g) == count_reg - CW'(1)))
                                  || (insert && (CW'(g) == count_reg));

        pelt_cell u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl[g]),
            .right_q (right_q),
            .bus     (bus),
            .entry_q (cell_q[g])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        synced_next   = synced_reg;
        next_id_next  = next_id_reg;
        drop_next     = drop_reg;
        compact_next  = compact_reg;
        iter_next     = iter_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        res_next      = res_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        done_next     = 1'b0;
        step          = 1'b0;
        keep          = 1'b0;
        insert        = 1'b0;
        bus           = head;
        match         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    iter_next  = count_reg;
                    res_next   = RES_OK;
                    if (cmd == CMD_APPEND)
                    begin
                        if (body_length > 8'(MAX_BODY))
                        begin
                            res_next   = RES_LENGTH;
                            state_next = ST_DONE;
                        end
                        else if (count_reg >= eff_cap)
                        begin
                            compact_next = 1'b1;
                            state_next   = ST_WALK;
                        end
                        else
                        begin
                            state_next = ST_INSERT;
                        end
                    end
                    else
                    begin
                        compact_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            res_next   = (cmd == CMD_OLDEST) ? RES_NONE : RES_NO_ID;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                step      = 1'b1;
                iter_next = iter_reg - CW'(1);
                pos_next  = pos_reg + CW'(1);
                if (compact_reg)
                begin
                    keep = !head.synced;
                    if (head.synced)
                    begin
                        count_next  = count_reg - CW'(1);
                        synced_next = synced_reg - CW'(1);
                    end
                    if (iter_reg == CW'(1))
                    begin
                        state_next = (count_next >= eff_cap) ? ST_DROP : ST_INSERT;
                    end
                end
                else
                begin
                    keep = 1'b1;
                    if (cmd_reg == CMD_OLDEST)
                    begin
                        match = !head.synced && ((head.kind != test_reg) || allow_reg);
                    end
                    else
                    begin
                        match = (head.id == target_reg);
                    end
                    if (match && !found_reg)
                    begin
                        found_next = 1'b1;
                        if (cmd_reg == CMD_SYNC)
                        begin
                            bus.synced = 1'b1;
                            if (!head.synced)
                            begin
                                synced_next = synced_reg + CW'(1);
                            end
                        end
                        else if (cmd_reg == CMD_TRY && head.tries != TRIES_MAX)
                        begin
                            bus.tries = head.tries + 8'd1;
                        end
                        hit_next      = bus;
                        hit_slot_next = pos_reg;
                    end
                    if (iter_reg == CW'(1))
                    begin
                        if (!found_next)
                        begin
                            res_next = (cmd_reg == CMD_OLDEST) ? RES_NONE : RES_NO_ID;
                        end
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DROP:
            begin
                step       = 1'b1;
                count_next = count_reg - CW'(1);
                if (head.synced)
                begin
                    synced_next = synced_reg - CW'(1);
                end
                drop_next  = drop_reg + 32'd1;
                state_next = ST_INSERT;
            end

            ST_INSERT:
            begin
                insert        = 1'b1;
                bus           = new_entry;
                count_next    = count_reg + CW'(1);
                next_id_next  = next_id_reg + 32'd1;
                hit_next      = new_entry;
                hit_slot_next = count_reg;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            synced_reg  <= '0;
            next_id_reg <= 32'd1;
            drop_reg    <= '0;
            cap_reg     <= CAP_W'(64);
            boot_reg    <= '0;
            test_reg    <= '0;
            compact_reg <= 1'b0;
            iter_reg    <= '0;
            pos_reg     <= '0;
            found_reg   <= 1'b0;
            res_reg     <= RES_OK;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            synced_reg  <= synced_next;
            next_id_reg <= next_id_next;
            drop_reg    <= drop_next;
            compact_reg <= compact_next;
            iter_reg    <= iter_next;
            pos_reg     <= pos_next;
            found_reg   <= found_next;
            res_reg     <= res_next;
            done_reg    <= done_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_CAPACITY: cap_reg  <= cfg_data[CAP_W-1:0];
                    REG_BOOT:     boot_reg <= cfg_data;
                    REG_TEST:     test_reg <= cfg_data[3:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
        if (accept)
        begin
            cmd_reg    <= cmd;
            kind_reg   <= event_kind;
            node_reg   <= source_node;
            len_reg    <= body_length;
            stamp_reg  <= stamp_ms;
            target_reg <= target_id;
            allow_reg  <= allow_test;
        end
        if (state_reg == ST_DONE)
        begin
            out_res_reg  <= res_reg;
            out_rec_reg  <= (res_reg == RES_OK) ? hit_reg : '0;
            out_slot_reg <= (res_reg == RES_OK) ? hit_slot_reg[SLOT_W-1:0] : '0;
            out_pend_reg <= PEND_W'(count_reg - synced_reg);
            out_drop_reg <= drop_reg;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign outcome       = out_res_reg;
    assign record_id     = out_rec_reg.id;
    assign record_kind   = out_rec_reg.kind;
    assign record_node   = out_rec_reg.node;
    assign record_length = out_rec_reg.length;
    assign record_boot   = out_rec_reg.boot;
    assign record_stamp  = out_rec_reg.stamp;
    assign record_tries  = out_rec_reg.tries;
    assign slot_number   = out_slot_reg;
    assign pending_total = out_pend_reg;
    assign dropped_total = out_drop_reg;

`ifndef NO_ASSERTIONS
    a_synced_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        synced_reg <= count_reg)
        else $error("synced entries exceed stored entries");

    a_count_within_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    // a lowered capacity can leave more entries than the capacity, never a full row
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT) |-> (count_reg < CW'(TABLE_DEPTH)))
        else $error("insert into a full cell row");
`endif

endmodule

`default_nettype wire

// File: sv/pelt_cell.sv
// One table slot of the cell row: holds an entry, takes its right neighbour
// on a shift or the shared bus on a load. Depends on pelt_pkg.
`default_nettype none

module pelt_cell
    import pelt_pkg::*;
(
    input  wire             clk,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     right_q,
    input  wire entry_t     bus,
    output entry_t          entry_q
);

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= bus;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= right_q;
        end
    end

    assign entry_q = entry_reg;

endmodule

`default_nettype wire

// File: tb/pending_event_log_table_core_test.sv
// Self-checking bench for pending_event_log_table_core: drives append, mark,
// attempt and oldest-pending commands and checks each result against a predictor.
// Depends on pelt_pkg and the core RTL.
`timescale 1ns / 100ps

import pelt_pkg::*;

typedef struct {
    logic [1:0]  outcome;
    logic [31:0] id;
    logic [3:0]  kind;
    logic [7:0]  node;
    logic [7:0]  length;
    logic [31:0] boot;
    logic [31:0] stamp;
    logic [7:0]  tries;
    logic [5:0]  slot;
    logic [6:0]  pending;
    logic [31:0] dropped;
} log_result_t;

class event_log_scoreboard;
    entry_t      rows[$];
    logic [31:0] next_id;
    logic [31:0] drops;
    logic [6:0]  capacity;
    logic [31:0] boot_reg;
    logic [3:0]  test_kind;
    log_result_t awaited[$];
    int          errors;

    function new();
        rows.delete();
        next_id   = 1;
        drops     = 0;
        capacity  = 7'd64;
        boot_reg  = 0;
        test_kind = 0;
        errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        if (idx == REG_CAPACITY) capacity = data[6:0];
        else if (idx == REG_BOOT) boot_reg = data;
        else if (idx == REG_TEST) test_kind = data[3:0];
    endfunction

    function log_result_t pack_row(logic [1:0] oc, int pos);
        log_result_t r;
        int pend;
        pend = 0;
        foreach (rows[i]) if (!rows[i].synced) pend++;
        r = '{outcome: oc, id: 0, kind: 0, node: 0, length: 0, boot: 0, stamp: 0,
              tries: 0, slot: 0, pending: pend[6:0], dropped: drops};
        if (pos >= 0) begin
            r.id = rows[pos].id;
            r.kind = rows[pos].kind;
            r.node = rows[pos].node;
            r.length = rows[pos].length;
            r.boot = rows[pos].boot;
            r.stamp = rows[pos].stamp;
            r.tries = rows[pos].tries;
            r.slot = pos[5:0];
        end
        return r;
    endfunction

    function void note_command(logic [1:0] c, logic [3:0] kind, logic [7:0] node,
                               logic [7:0] len, logic [31:0] stamp,
                               logic [31:0] tid, logic allow);
        int cap;
        int pos;
        entry_t e;
        pos = -1;
        if (c == CMD_APPEND) begin
            cap = capacity;
            if (cap < 1) cap = 1;
            if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
            if (len > MAX_BODY) begin
                awaited.push_back(pack_row(RES_LENGTH, -1));
                return;
            end
            if (rows.size() >= cap) begin
                for (int i = rows.size() - 1; i >= 0; i--)
                    if (rows[i].synced) rows.delete(i);
                if (rows.size() >= cap) begin
                    void'(rows.pop_front());
                    drops++;
                end
            end
            e = '{id: next_id, kind: kind, node: node, length: len, boot: boot_reg,
                  stamp: stamp, synced: 1'b0, tries: 8'd0};
            rows.push_back(e);
            next_id++;
            awaited.push_back(pack_row(RES_OK, rows.size() - 1));
        end else if (c == CMD_SYNC || c == CMD_TRY) begin
            foreach (rows[i]) if (pos < 0 && rows[i].id == tid) pos = i;
            if (pos < 0) begin
                awaited.push_back(pack_row(RES_NO_ID, -1));
                return;
            end
            if (c == CMD_SYNC) rows[pos].synced = 1'b1;
            else if (rows[pos].tries != TRIES_MAX) rows[pos].tries++;
            awaited.push_back(pack_row(RES_OK, pos));
        end else begin
            foreach (rows[i])
                if (pos < 0 && !rows[i].synced && (allow || rows[i].kind != test_kind))
                    pos = i;
            awaited.push_back(pack_row(pos < 0 ? RES_NONE : RES_OK, pos));
        end
    endfunction

    function void check_result(log_result_t got);
        log_result_t w;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result, outcome %0d", $time, got.outcome);
            errors++;
            return;
        end
        w = awaited.pop_front();
        if (got.outcome !== w.outcome) report("outcome", w.outcome, got.outcome);
        if (got.id !== w.id) report("record_id", w.id, got.id);
        if (got.kind !== w.kind) report("record_kind", w.kind, got.kind);
        if (got.node !== w.node) report("record_node", w.node, got.node);
        if (got.length !== w.length) report("record_length", w.length, got.length);
        if (got.boot !== w.boot) report("record_boot", w.boot, got.boot);
        if (got.stamp !== w.stamp) report("record_stamp", w.stamp, got.stamp);
        if (got.tries !== w.tries) report("record_tries", w.tries, got.tries);
        if (got.slot !== w.slot) report("slot_number", w.slot, got.slot);
        if (got.pending !== w.pending) report("pending_total", w.pending, got.pending);
        if (got.dropped !== w.dropped) report("dropped_total", w.dropped, got.dropped);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        errors++;
    endfunction
endclass

module pending_event_log_table_core_test;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = CMD_APPEND;
    logic [3:0]  event_kind = '0;
    logic [7:0]  source_node = '0;
    logic [7:0]  body_length = '0;
    logic [31:0] stamp_ms = '0;
    logic [31:0] target_id = '0;
    logic        allow_test = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        done;
    logic [1:0]  outcome;
    logic [31:0] record_id;
    logic [3:0]  record_kind;
    logic [7:0]  record_node;
    logic [7:0]  record_length;
    logic [31:0] record_boot;
    logic [31:0] record_stamp;
    logic [7:0]  record_tries;
    logic [5:0]  slot_number;
    logic [6:0]  pending_total;
    logic [31:0] dropped_total;

    event_log_scoreboard board;
    int cycles = 0;
    int burst_left = 0;

    always #6 clk = ~clk;

    pending_event_log_table_core dut (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done && board != null)
            board.check_result('{outcome: outcome, id: record_id, kind: record_kind,
                node: record_node, length: record_length, boot: record_boot,
                stamp: record_stamp, tries: record_tries, slot: slot_number,
                pending: pending_total, dropped: dropped_total});
    end

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Idle point for register writes: everything back and a short settle.
    task automatic drain();
        while (board.awaited.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic issue(logic [1:0] c, logic [3:0] k, logic [7:0] n, logic [7:0] l,
                         logic [31:0] s, logic [31:0] t, logic a);
        // sender gaps between bursts
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        burst_left--;
        start <= 1'b1;
        cmd <= c;
        event_kind <= k;
        source_node <= n;
        body_length <= l;
        stamp_ms <= s;
        target_id <= t;
        allow_test <= a;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_command(c, k, n, l, s, t, a);
        start <= 1'b0;
        // the block turns busy at the accepting edge
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_id();
        int sz;
        sz = board.rows.size();
        if (sz == 0 || $urandom_range(0, 9) == 0) return $urandom();
        return board.rows[$urandom_range(0, sz - 1)].id;
    endfunction

    task automatic random_items(int count);
        int r;
        logic [1:0] c;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            c = r < 45 ? CMD_APPEND : r < 70 ? CMD_SYNC : r < 85 ? CMD_TRY : CMD_OLDEST;
            issue(c, 4'($urandom_range(0, 15)), 8'($urandom()),
                  $urandom_range(0, 9) == 0 ? 8'($urandom())
                                            : 8'($urandom_range(0, MAX_BODY)),
                  $urandom(), pick_id(), 1'($urandom()));
        end
    endtask

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, length limits
        issue(CMD_OLDEST, '0, '0, '0, '0, '0, 1'b1);
        issue(CMD_SYNC, '0, '0, '0, '0, 32'd1, 1'b0);
        issue(CMD_APPEND, 4'hf, 8'hff, 8'(MAX_BODY), 32'hffffffff, '0, 1'b0);
        issue(CMD_APPEND, 4'h0, 8'h00, 8'd0, 32'h0, '0, 1'b0);
        issue(CMD_APPEND, 4'h3, 8'h55, 8'(MAX_BODY + 1), 32'h1234, '0, 1'b0);
        issue(CMD_APPEND, 4'h3, 8'h55, 8'hff, 32'h1234, '0, 1'b0);
        issue(CMD_OLDEST, '0, '0, '0, '0, '0, 1'b0);
        issue(CMD_OLDEST, '0, '0, '0, '0, '0, 1'b1);
        issue(CMD_SYNC, '0, '0, '0, '0, 32'd1, 1'b0);
        issue(CMD_SYNC, '0, '0, '0, '0, 32'd1, 1'b0);
        issue(CMD_TRY, '0, '0, '0, '0, 32'd1, 1'b0);
        issue(CMD_TRY, '0, '0, '0, '0, 32'hffffffff, 1'b0);
        for (int i = 0; i < 257; i++) issue(CMD_TRY, '0, '0, '0, '0, 32'd2, 1'b0);
        drain();

        // small capacity: compaction and drops; boot and test code set
        write_cfg(REG_CAPACITY, 32'd3);
        write_cfg(REG_BOOT, 32'hffffffff);
        write_cfg(REG_TEST, 32'd15);
        for (int i = 0; i < 8; i++) issue(CMD_APPEND, 4'(i), 8'(i), 8'd1, 32'(i), '0, 1'b0);
        issue(CMD_OLDEST, '0, '0, '0, '0, '0, 1'b0);
        random_items(100);
        drain();

        // zero capacity acts as one; values above depth act as depth
        write_cfg(REG_CAPACITY, 32'd0);
        write_cfg(REG_BOOT, $urandom());
        write_cfg(REG_TEST, $urandom_range(0, 15));
        random_items(80);
        drain();
        write_cfg(REG_CAPACITY, 32'd127);
        random_items(120);
        drain();
        // lowered capacity with a fuller table
        write_cfg(REG_CAPACITY, 32'd1);
        write_cfg(REG_BOOT, 32'd0);
        random_items(60);
        drain();
        write_cfg(REG_CAPACITY, 32'd64);
        write_cfg(REG_TEST, 32'd0);
        random_items(110);

        while (board.awaited.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
